// File: sv/generational_slot_allocator_core_macros.svh
// Assertion macros shared by the slot allocator modules.
// No dependencies; expects signals clk and arst_n in the including module.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_CORE_MACROS_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition holds at every edge outside reset
`define GSA_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("gsa assertion failed");

// Consequent holds in the same cycle as the antecedent
`define GSA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gsa assertion failed");

// Consequent holds in the cycle after the antecedent
`define GSA_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gsa assertion failed");

`else

`define GSA_ASSERT(label, cond)
`define GSA_ASSERT_IMP(label, ante, cons)
`define GSA_ASSERT_NXT(label, ante, cons)

`endif

`endif

// File: sv/gsa_pkg.sv
// Shared constants and types for the generational slot allocator.
// No dependencies; imported by every module of the block.
package gsa_pkg;

	// Pool size and field widths
	localparam int unsigned SLOTS   = 64;
	localparam int unsigned IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned CNT_W   = $clog2(SLOTS + 1);
	localparam int unsigned INDEX_W = 12;
	localparam int unsigned GEN_W   = 32;

	// Request modes
	typedef logic [1:0] mode_t;
	localparam mode_t MODE_ACQUIRE = 2'd0;
	localparam mode_t MODE_RELEASE = 2'd1;
	localparam mode_t MODE_CHECK   = 2'd2;

	// Result status codes
	typedef logic [1:0] status_t;
	localparam status_t STAT_OK    = 2'd0;
	localparam status_t STAT_FULL  = 2'd1;
	localparam status_t STAT_RANGE = 2'd2;
	localparam status_t STAT_STALE = 2'd3;

	// Slot state codes
	typedef logic [1:0] slot_state_t;
	localparam slot_state_t ST_FREE = 2'd0;
	localparam slot_state_t ST_LIVE = 2'd1;
	localparam slot_state_t ST_TEST = 2'd2;

	// One slot table record
	typedef struct packed {
		slot_state_t        state;
		logic [GEN_W-1:0]   gen;
	} slot_rec_t;

	// Slot table write
	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   addr;
		slot_rec_t          rec;
	} slot_wr_t;

	// Free stack entry: index with the generation it will be handed out at
	typedef struct packed {
		logic [IDX_W-1:0]   idx;
		logic [GEN_W-1:0]   gen;
	} stk_entry_t;

	// Free stack update for the committing request
	typedef struct packed {
		logic               push;
		logic               pop;
		stk_entry_t         entry;
	} stk_op_t;

	// Request held in the input stage
	typedef struct packed {
		mode_t              mode;
		logic               kind;
		logic [INDEX_W-1:0] index;
		logic [GEN_W-1:0]   gen;
	} req_t;

endpackage

// File: sv/gsa_slot_table.sv
// Per-slot state and generation memory with registered read and write bypass.
// Depends on gsa_pkg. Entries never written read as free with generation zero.
module gsa_slot_table
	import gsa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	input  slot_wr_t         wr,
	output slot_rec_t        rd_rec
);

	slot_rec_t        mem [SLOTS];
	logic [SLOTS-1:0] vld_q;
	slot_rec_t        raw_s1;
	slot_rec_t        byp_s1;
	logic             vld_s1;
	logic             hit_s1;

	// Write committing record, read for the incoming request
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.rec;
		end
		if (rd_en) begin
			raw_s1 <= mem[rd_addr];
			byp_s1 <= wr.rec;
		end
	end

	// Mark written entries valid; capture bypass and valid flags on read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
			hit_s1 <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= vld_q[rd_addr];
				hit_s1 <= wr.en && (wr.addr == rd_addr);
			end
		end
	end

	// Resolve bypass, then reset value for untouched entries
	always_comb begin
		if (hit_s1) begin
			rd_rec = byp_s1;
		end else if (vld_s1) begin
			rd_rec = raw_s1;
		end else begin
			rd_rec.state = ST_FREE;
			rd_rec.gen   = '0;
		end
	end

endmodule

// File: sv/gsa_free_stack.sv
// Free index stack: memory of index/generation entries plus the fill count.
// Depends on gsa_pkg and the assertion macro header.
`include "generational_slot_allocator_core_macros.svh"

module gsa_free_stack
	import gsa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  stk_op_t          op,
	output logic [CNT_W-1:0] count,
	output stk_entry_t       top
);

	stk_entry_t       mem [SLOTS];
	logic [SLOTS-1:0] vld_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] cnt_next;
	logic [CNT_W-1:0] raddr_full;
	logic [IDX_W-1:0] raddr;
	logic [IDX_W-1:0] waddr;
	logic             push_ok;
	stk_entry_t       raw_s1;
	stk_entry_t       byp_s1;
	logic [IDX_W-1:0] dflt_s1;
	logic             vld_s1;
	logic             hit_s1;

	// Drop a push into a full stack; read the top as it stands after this update
	assign push_ok    = op.push && (count_q < CNT_W'(SLOTS));
	assign cnt_next   = count_q + CNT_W'(push_ok) - CNT_W'(op.pop);
	assign raddr_full = cnt_next - CNT_W'(1);
	assign raddr      = raddr_full[IDX_W-1:0];
	assign waddr      = count_q[IDX_W-1:0];
	assign count      = count_q;

	// Push write and top read
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[waddr] <= op.entry;
		end
		if (rd_en) begin
			raw_s1  <= mem[raddr];
			byp_s1  <= op.entry;
			dflt_s1 <= IDX_W'(SLOTS - 1) - raddr;
		end
	end

	// Count, entry valid bits and read flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(SLOTS);
			vld_q   <= '0;
			vld_s1  <= 1'b0;
			hit_s1  <= 1'b0;
		end else begin
			count_q <= cnt_next;
			if (push_ok) begin
				vld_q[waddr] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= vld_q[raddr];
				hit_s1 <= push_ok && (waddr == raddr);
			end
		end
	end

	// Resolve bypass, then the reset contents for never-pushed entries
	always_comb begin
		if (hit_s1) begin
			top = byp_s1;
		end else if (vld_s1) begin
			top = raw_s1;
		end else begin
			top.idx = dflt_s1;
			top.gen = '0;
		end
	end

	`GSA_ASSERT(a_count_bound, count_q <= CNT_W'(SLOTS))
	`GSA_ASSERT_IMP(a_no_pop_empty, op.pop, count_q != '0)
	`GSA_ASSERT_NXT(a_push_counts, push_ok && !op.pop, count_q == $past(count_q) + CNT_W'(1))

endmodule

// File: sv/generational_slot_allocator_core.sv
// Channel   Dir  Signals                        Payload
// s_*       in   s_tvalid s_tready s_tdata s_tuser  request: handle index/generation, mode, kind
// m_*       out  m_tvalid m_tready m_tdata m_tuser  result: granted index/generation, status
//
// One request per cycle sustained while m_tready holds; a request taken sits in the input stage
// and its result is then registered into the output register, which drives m_*. The rate is
// set by the slot table and stack read-modify-write, kept at one per cycle by a bypass of the
// previous write.
// Reset clears the valid bits of both memories at once; no clearing pass is needed.
// A stalled result holds the output register; the input stage then holds, and s_tready
// falls only while both are full.
// Depends on gsa_pkg, gsa_slot_table, gsa_free_stack and the assertion macro header.
`include "generational_slot_allocator_core_macros.svh"

module generational_slot_allocator_core
	import gsa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [11:0] handle index, [43:12] handle_generation, zero pad
	input  logic [2:0]  s_tuser,   // [1:0] mode, [2] slot_kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [11:0] granted_index, [43:12] granted_generation, zero pad
	output logic [1:0]  m_tuser    // [1:0] status
);

	logic               accept;
	logic               advance;
	logic               commit;
	logic               valid_s1;
	req_t               req_s1;
	slot_rec_t          rec;
	stk_entry_t         top;
	logic [CNT_W-1:0]   count;
	slot_wr_t           slot_wr;
	stk_op_t            stk_op;
	slot_state_t        want;
	logic               in_range;
	logic               match;
	logic [GEN_W-1:0]   gen_inc;
	status_t            res_status;
	logic [INDEX_W-1:0] res_index;
	logic [GEN_W-1:0]   res_gen;
	logic               out_valid_q;
	status_t            out_status_q;
	logic [INDEX_W-1:0] out_index_q;
	logic [GEN_W-1:0]   out_gen_q;

	// Handshake: the input stage moves on whenever the output register is free or drained
	assign advance  = !out_valid_q || m_tready;
	assign commit   = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.mode  <= s_tuser[1:0];
			req_s1.kind  <= s_tuser[2];
			req_s1.index <= s_tdata[11:0];
			req_s1.gen   <= s_tdata[43:12];
		end
	end

	gsa_slot_table u_slot_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (s_tdata[IDX_W-1:0]),
		.wr      (slot_wr),
		.rd_rec  (rec)
	);

	gsa_free_stack u_free_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.op      (stk_op),
		.count   (count),
		.top     (top)
	);

	// Validate the handle against the slot record
	assign want     = req_s1.kind ? ST_TEST : ST_LIVE;
	assign in_range = ({1'b0, req_s1.index} < 13'(SLOTS));
	assign match    = (rec.state == want) && (rec.gen == req_s1.gen);
	assign gen_inc  = rec.gen + GEN_W'(1);

	// Decide the result and the table and stack updates
	always_comb begin
		res_status      = STAT_OK;
		res_index       = req_s1.index;
		res_gen         = rec.gen;
		slot_wr.en      = 1'b0;
		slot_wr.addr    = req_s1.index[IDX_W-1:0];
		slot_wr.rec     = rec;
		stk_op.push     = 1'b0;
		stk_op.pop      = 1'b0;
		stk_op.entry.idx = req_s1.index[IDX_W-1:0];
		stk_op.entry.gen = gen_inc;
		case (req_s1.mode)
			MODE_ACQUIRE: begin
				if (count == '0) begin
					res_status = STAT_FULL;
					res_index  = '0;
					res_gen    = '0;
				end else begin
					res_index         = INDEX_W'(top.idx);
					res_gen           = top.gen;
					slot_wr.en        = commit;
					slot_wr.addr      = top.idx;
					slot_wr.rec.state = want;
					slot_wr.rec.gen   = top.gen;
					stk_op.pop        = commit;
				end
			end
			default: begin
				if (!in_range) begin
					res_status = STAT_RANGE;
					res_gen    = '0;
				end else if (!match) begin
					res_status = STAT_STALE;
				end else if (req_s1.mode == MODE_RELEASE) begin
					res_gen           = gen_inc;
					slot_wr.en        = commit;
					slot_wr.rec.state = ST_FREE;
					slot_wr.rec.gen   = gen_inc;
					stk_op.push       = commit;
				end
			end
		endcase
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (commit) begin
			out_status_q <= res_status;
			out_index_q  <= res_index;
			out_gen_q    <= res_gen;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {4'b0, out_gen_q, out_index_q};

	`GSA_ASSERT_IMP(a_ok_index_in_range, commit && (res_status == STAT_OK),
		{1'b0, res_index} < 13'(SLOTS))
	`GSA_ASSERT(a_no_push_and_pop, !(stk_op.push && stk_op.pop))
	`GSA_ASSERT_NXT(a_commit_fills_output, commit, out_valid_q)

endmodule
